FILE: sv/dpst_pkg.sv
`default_nettype none
package dpst_pkg;

  localparam int PHASE_W  = 26;
  localparam int DEG_W    = 9;
  localparam int FREQ_W   = 15;
  localparam int RATE_W   = 18;
  localparam int CHCNT_W  = 4;
  localparam int SAMPLE_W = 16;
  localparam int CHIDX_W  = 3;
  localparam int CFG_W    = 18;
  localparam int CFG_IDX_W = 2;
  localparam int QUO_W    = FREQ_W + 16;

  localparam logic [PHASE_W-1:0] TURN = PHASE_W'(360 << 16);

  localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQ     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [FREQ_W-1:0]  RST_TONE_FREQ     = 15'd440;
  localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE   = 18'd48000;
  localparam logic [CHCNT_W-1:0] RST_CHANNEL_COUNT = 4'd2;
  localparam logic [PHASE_W-1:0] RST_INCREMENT     = 26'd216000;

  localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
  localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
  localparam logic [DEG_W-1:0] DEG_360 = 9'd360;

  localparam logic [14:0] SINE_K     = 15'd16570;
  localparam logic [14:0] FULL_SCALE = 15'd32767;
  localparam logic [8:0]  DEG_TURN   = 9'd360;

  typedef struct packed {
    logic [PHASE_W-1:0] inc;
    logic [CHCNT_W-1:0] chan_count;
    logic               busy;
  } cfg_state_t;

endpackage
`default_nettype wire

FILE: sv/dds_parabolic_sine_tone_generator.sv
`default_nettype none
// channel  dir  handshake        payload
// in       in   valid / stall    frame_tick
// out      out  valid / stall    sample, channel_index, last_of_frame
// cfg      in   we               index, data (18 bits)
//
// sample formed in FOLD, SCALE; then one item per cycle per channel unless out stalls
// a register write recomputes the increment by division, one quotient bit per cycle;
// the input stalls meanwhile; a zero sample rate gives increment zero without dividing
// reset: registers 440 / 48000 / 2, phase zero, increment 216000; no clearing pass
// a two-entry queue between front and back lets input continue while outputs stall
module dds_parabolic_sine_tone_generator #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_frame_tick,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [dpst_pkg::SAMPLE_W-1:0] out_sample,
  output logic [dpst_pkg::CHIDX_W-1:0]         out_channel_index,
  output logic                                 out_last_of_frame,
  input  wire                                  cfg_we,
  input  wire  [dpst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [dpst_pkg::CFG_W-1:0]           cfg_data
);

  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int QW = dpst_pkg::DEG_W + CW;

  dpst_pkg::cfg_state_t cfg_state;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  dpst_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_state (cfg_state)
  );

  dpst_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CW           (CW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_tick (in_frame_tick),
    .cfg_state     (cfg_state),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  dpst_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  dpst_back #(
    .CW (CW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample),
    .out_channel_index (out_channel_index),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
`default_nettype wire

FILE: sv/dpst_cfg.sv
`default_nettype none
module dpst_cfg (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire  [dpst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [dpst_pkg::CFG_W-1:0]           cfg_data,
  output dpst_pkg::cfg_state_t                 cfg_state
);

  logic [dpst_pkg::FREQ_W-1:0]  freq_r, freq_nxt;
  logic [dpst_pkg::RATE_W-1:0]  rate_r, rate_nxt;
  logic [dpst_pkg::CHCNT_W-1:0] chcnt_r, chcnt_nxt;
  logic [dpst_pkg::PHASE_W-1:0] inc_r, inc_nxt;
  logic                         busy_r, busy_nxt;
  logic [4:0]                   cnt_r, cnt_nxt;
  logic [dpst_pkg::RATE_W-1:0]  rem_r, rem_nxt;
  logic [dpst_pkg::QUO_W-1:0]   quo_r, quo_nxt;

  logic [dpst_pkg::RATE_W:0]    rem_sh;
  logic                         ge;
  logic [dpst_pkg::RATE_W:0]    rem_sub;
  logic [dpst_pkg::QUO_W-1:0]   quo_step;
  logic                         wr_hit;

  always_comb begin
    rem_sh   = {rem_r, quo_r[dpst_pkg::QUO_W-1]};
    ge       = rem_sh >= {1'b0, rate_r};
    rem_sub  = rem_sh - {1'b0, rate_r};
    quo_step = {quo_r[dpst_pkg::QUO_W-2:0], ge};
  end

  always_comb begin
    freq_nxt  = freq_r;
    rate_nxt  = rate_r;
    chcnt_nxt = chcnt_r;
    inc_nxt   = inc_r;
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    wr_hit    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        dpst_pkg::REG_TONE_FREQ: begin
          freq_nxt = cfg_data[dpst_pkg::FREQ_W-1:0];
          wr_hit   = 1'b1;
        end
        dpst_pkg::REG_SAMPLE_RATE: begin
          rate_nxt = cfg_data[dpst_pkg::RATE_W-1:0];
          wr_hit   = 1'b1;
        end
        dpst_pkg::REG_CHANNEL_COUNT: begin
          chcnt_nxt = cfg_data[dpst_pkg::CHCNT_W-1:0];
          wr_hit    = 1'b1;
        end
        default: wr_hit = 1'b0;
      endcase
    end
    if (wr_hit) begin
      rem_nxt = '0;
      quo_nxt = {freq_nxt, 16'd0};
      cnt_nxt = 5'(dpst_pkg::QUO_W - 1);
      if (rate_nxt == '0) begin
        busy_nxt = 1'b0;
        inc_nxt  = '0;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[dpst_pkg::RATE_W-1:0] : rem_sh[dpst_pkg::RATE_W-1:0];
      quo_nxt = quo_step;
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        // 360 per unit of the low 16 quotient bits; whole turns give one turn
        if (quo_step == '0) begin
          inc_nxt = '0;
        end else if (quo_step[15:0] == 16'd0) begin
          inc_nxt = dpst_pkg::TURN;
        end else begin
          inc_nxt = dpst_pkg::PHASE_W'(quo_step[15:0] * dpst_pkg::DEG_TURN);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r  <= dpst_pkg::RST_TONE_FREQ;
      rate_r  <= dpst_pkg::RST_SAMPLE_RATE;
      chcnt_r <= dpst_pkg::RST_CHANNEL_COUNT;
      inc_r   <= dpst_pkg::RST_INCREMENT;
      busy_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      freq_r  <= freq_nxt;
      rate_r  <= rate_nxt;
      chcnt_r <= chcnt_nxt;
      inc_r   <= inc_nxt;
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign cfg_state.inc        = inc_r;
  assign cfg_state.chan_count = chcnt_r;
  assign cfg_state.busy       = busy_r;

  a_inc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    inc_r <= dpst_pkg::TURN)
    else $error("increment beyond one turn");

endmodule
`default_nettype wire

FILE: sv/dpst_front.sv
`default_nettype none
module dpst_front #(
  parameter int MAX_CHANNELS = 8,
  parameter int CW           = 4
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            in_frame_tick,
  input  wire dpst_pkg::cfg_state_t      cfg_state,
  input  wire                            q_full,
  output logic                           q_push,
  output logic [dpst_pkg::DEG_W+CW-1:0]  q_wdata
);

  logic [dpst_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [dpst_pkg::PHASE_W-1:0] sum;
  logic [4:0]                   cc_ext;
  logic [CW-1:0]                n_sat;
  logic                         accept;

  assign in_stall = cfg_state.busy || q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && in_frame_tick;

  always_comb begin
    cc_ext = {1'b0, cfg_state.chan_count};
    if (cc_ext > 5'(MAX_CHANNELS)) begin
      n_sat = CW'(MAX_CHANNELS);
    end else begin
      n_sat = CW'(cfg_state.chan_count);
    end
  end

  assign q_wdata = {phase_r[dpst_pkg::DEG_W+15:16], n_sat};

  always_comb begin
    sum = phase_r + cfg_state.inc;
    if (sum > dpst_pkg::TURN) begin
      sum = sum - dpst_pkg::TURN;
    end
    phase_nxt = q_push ? sum : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> phase_r <= dpst_pkg::TURN)
    else $error("phase left one turn");

endmodule
`default_nettype wire

FILE: sv/dpst_queue.sv
`default_nettype none
module dpst_queue #(
  parameter int W = 13
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  input  wire [W-1:0]  wdata,
  input  wire          pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("queue overflow or underflow");

endmodule
`default_nettype wire

FILE: sv/dpst_back.sv
`default_nettype none
module dpst_back #(
  parameter int CW = 4
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  q_empty,
  input  wire  [dpst_pkg::DEG_W+CW-1:0]        q_rdata,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [dpst_pkg::SAMPLE_W-1:0] out_sample,
  output logic [dpst_pkg::CHIDX_W-1:0]         out_channel_index,
  output logic                                 out_last_of_frame
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FOLD  = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [dpst_pkg::DEG_W-1:0]   deg_r, deg_nxt;
  logic [CW-1:0]                n_r, n_nxt;
  logic [CW-1:0]                k_r, k_nxt;
  logic [12:0]                  xx_r, xx_nxt;
  logic                         neg_r, neg_nxt;
  logic [26:0]                  prod_r, prod_nxt;
  logic                         ov_r, ov_nxt;
  logic signed [dpst_pkg::SAMPLE_W-1:0] smp_r, smp_nxt;
  logic [dpst_pkg::CHIDX_W-1:0] idx_r, idx_nxt;
  logic                         last_r, last_nxt;

  logic [dpst_pkg::DEG_W-1:0]   x;
  logic                         neg;
  logic [27:0]                  prod_full;
  logic [14:0]                  mag;
  logic signed [dpst_pkg::SAMPLE_W-1:0] smp_cur;
  logic [CW+2:0]                k_ext;
  logic                         load;
  logic                         last_k;

  always_comb begin
    if (deg_r >= dpst_pkg::DEG_90) begin
      x = deg_r - dpst_pkg::DEG_90;
    end else begin
      x = dpst_pkg::DEG_90 - deg_r;
    end
    if (x >= dpst_pkg::DEG_360) begin
      x = x - dpst_pkg::DEG_360;
    end
    if (x >= dpst_pkg::DEG_180) begin
      x = dpst_pkg::DEG_360 - x;
    end
    neg = 1'b0;
    if (x >= dpst_pkg::DEG_90) begin
      neg = 1'b1;
      x   = dpst_pkg::DEG_180 - x;
    end
  end

  assign prod_full = xx_r * dpst_pkg::SINE_K;
  assign mag       = dpst_pkg::FULL_SCALE - prod_r[26:12];
  assign smp_cur   = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign k_ext     = (CW+3)'(k_r);
  assign last_k    = (k_r + CW'(1)) == n_r;
  assign load      = !ov_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    deg_nxt   = deg_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    xx_nxt    = xx_r;
    neg_nxt   = neg_r;
    prod_nxt  = prod_r;
    ov_nxt    = ov_r;
    smp_nxt   = smp_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    if (load) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          deg_nxt = q_rdata[dpst_pkg::DEG_W+CW-1:CW];
          n_nxt   = q_rdata[CW-1:0];
          k_nxt   = '0;
          if (q_rdata[CW-1:0] != '0) begin
            state_nxt = ST_FOLD;
          end
        end
      end
      ST_FOLD: begin
        xx_nxt    = 13'(x[6:0] * x[6:0]);
        neg_nxt   = neg;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        prod_nxt  = prod_full[26:0];
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          ov_nxt   = 1'b1;
          smp_nxt  = smp_cur;
          idx_nxt  = k_ext[2:0];
          last_nxt = last_k;
          k_nxt    = k_r + CW'(1);
          if (last_k) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deg_r  <= deg_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    xx_r   <= xx_nxt;
    neg_r  <= neg_nxt;
    prod_r <= prod_nxt;
    smp_r  <= smp_nxt;
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
  end

  assign out_valid         = ov_r;
  assign out_sample        = smp_r;
  assign out_channel_index = idx_r;
  assign out_last_of_frame = last_r;

  a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_stall && !last_r |=> ov_r)
    else $error("gap inside a frame");

  a_sample_held_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_stall && !last_r |=> $stable(smp_r))
    else $error("sample changed inside a frame");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !ov_r || last_r)
    else $error("new frame popped while a frame is open");

endmodule
`default_nettype wire
